>>> rtl/selt_pkg.sv
// Package for the shared/exclusive lock table: controller state type,
// result status codes, request flag bit positions and command codes. No dependencies.
`default_nettype none

package selt_pkg;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_TAIL,
      S_FINISH
   } state_type;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_BAD_HANDLE = 3'd1;
   localparam logic [2:0] STATUS_INVALID    = 3'd2;
   localparam logic [2:0] STATUS_WOULDBLOCK = 3'd3;
   localparam logic [2:0] STATUS_NO_LOCK    = 3'd4;

   localparam int OP_SHARED_BIT    = 0;
   localparam int OP_EXCLUSIVE_BIT = 1;
   localparam int OP_NONBLOCK_BIT  = 2;
   localparam int OP_UNLOCK_BIT    = 3;

   localparam logic CMD_LOCK    = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/selt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the lock table entries; no dependencies.
`default_nettype none

module selt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/shared_exclusive_lock_table_core.sv
// Top level of the shared/exclusive lock table: request controller around one
// entry RAM. Depends on selt_pkg and selt_ram.
//
// One request is handled at a time. After start is taken, the controller reads
// every table entry once through the RAM's single read port, then decides and
// writes back at most one entry: it steps through S_SCAN, S_TAIL and S_FINISH,
// and the result strobe is registered from S_FINISH. A new request is taken
// only in S_IDLE. After reset a clearing pass zeroes every table entry while
// busy is high. The result beat is shown for one cycle on rsp_valid and
// rsp_status and cannot be held off.
`default_nettype none

module shared_exclusive_lock_table_core #(
   parameter int ENTRIES     = 64,
   parameter int HANDLE_BITS = 16,
   parameter int KEY_BITS    = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_cmd,
   input  wire logic [HANDLE_BITS-1:0] req_holder_handle,
   input  wire logic [KEY_BITS-1:0]    req_object_key,
   input  wire logic [3:0]             req_op_bits,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status
);

   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int ENTRY_BITS = HANDLE_BITS + KEY_BITS + 1;

   selt_pkg::state_type state_ff, state_in;

   logic [IDX_BITS-1:0]    addr_ff, addr_in;
   logic                   chk_valid_ff;
   logic [IDX_BITS-1:0]    chk_idx_ff;

   logic                   cmd_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [3:0]             op_ff;

   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    found_idx_ff, found_idx_in;
   logic [KEY_BITS-1:0]    found_key_ff, found_key_in;
   logic                   free_ff, free_in;
   logic [IDX_BITS-1:0]    free_idx_ff, free_idx_in;
   logic                   conflict_ff, conflict_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;

   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [ENTRY_BITS-1:0]  wr_data;
   logic                   rd_en;
   logic [ENTRY_BITS-1:0]  rd_data;

   logic [HANDLE_BITS-1:0] rd_holder;
   logic [KEY_BITS-1:0]    rd_key;
   logic                   rd_excl;
   logic                   want_ex;
   logic                   accept;
   logic                   last_addr;

   selt_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign rd_holder = rd_data[ENTRY_BITS-1 -: HANDLE_BITS];
   assign rd_key    = rd_data[KEY_BITS:1];
   assign rd_excl   = rd_data[0];
   assign want_ex   = op_ff[selt_pkg::OP_EXCLUSIVE_BIT];
   assign busy      = (state_ff != selt_pkg::S_IDLE);
   assign accept    = start && (state_ff == selt_pkg::S_IDLE);
   assign last_addr = (addr_ff == IDX_BITS'(ENTRIES - 1));
   assign rd_en     = (state_ff == selt_pkg::S_SCAN);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= selt_pkg::S_CLEAR;
         addr_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         chk_valid_ff <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= addr_ff;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_key_ff  <= found_key_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      conflict_ff   <= conflict_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         handle_ff <= req_holder_handle;
         key_ff    <= req_object_key;
         op_ff     <= req_op_bits;
      end
   end

   // Scan bookkeeping: first entry of the holder, first free entry, conflict.
   always_comb begin
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_key_in = found_key_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      conflict_in  = conflict_ff;
      if (accept) begin
         found_in    = 1'b0;
         free_in     = 1'b0;
         conflict_in = 1'b0;
      end else if (chk_valid_ff) begin
         if (!found_ff && rd_holder == handle_ff) begin
            found_in     = 1'b1;
            found_idx_in = chk_idx_ff;
            found_key_in = rd_key;
         end
         if (!free_ff && rd_holder == '0) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
         if (rd_holder != '0 && rd_holder != handle_ff && rd_key == key_ff &&
             (want_ex || rd_excl)) begin
            conflict_in = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = selt_pkg::STATUS_OK;
      case (state_ff)
         selt_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + IDX_BITS'(1);
            if (last_addr) begin
               addr_in  = '0;
               state_in = selt_pkg::S_IDLE;
            end
         end
         selt_pkg::S_IDLE: begin
            addr_in = '0;
            if (accept) begin
               state_in = selt_pkg::S_SCAN;
            end
         end
         selt_pkg::S_SCAN: begin
            addr_in = addr_ff + IDX_BITS'(1);
            if (last_addr) begin
               addr_in  = '0;
               state_in = selt_pkg::S_TAIL;
            end
         end
         selt_pkg::S_TAIL: begin
            state_in = selt_pkg::S_FINISH;
         end
         selt_pkg::S_FINISH: begin
            state_in     = selt_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
            wr_addr      = found_idx_ff;
            if (cmd_ff == selt_pkg::CMD_LOCK && handle_ff == '0) begin
               rsp_status_in = selt_pkg::STATUS_BAD_HANDLE;
            end else if (cmd_ff == selt_pkg::CMD_LOCK &&
                         op_ff[selt_pkg::OP_UNLOCK_BIT] &&
                         (op_ff[selt_pkg::OP_SHARED_BIT] ||
                          op_ff[selt_pkg::OP_EXCLUSIVE_BIT])) begin
               rsp_status_in = selt_pkg::STATUS_INVALID;
            end else if (cmd_ff == selt_pkg::CMD_RELEASE ||
                         op_ff[selt_pkg::OP_UNLOCK_BIT]) begin
               wr_en = (handle_ff != '0) && found_ff;
            end else if (op_ff[selt_pkg::OP_SHARED_BIT] ==
                         op_ff[selt_pkg::OP_EXCLUSIVE_BIT]) begin
               rsp_status_in = selt_pkg::STATUS_INVALID;
            end else if (conflict_ff) begin
               rsp_status_in = op_ff[selt_pkg::OP_NONBLOCK_BIT] ?
                               selt_pkg::STATUS_WOULDBLOCK : selt_pkg::STATUS_NO_LOCK;
            end else if (found_ff) begin
               wr_en   = 1'b1;
               wr_data = {handle_ff, found_key_ff, want_ex};
            end else if (free_ff) begin
               wr_en   = 1'b1;
               wr_addr = free_idx_ff;
               wr_data = {handle_ff, key_ff, want_ex};
            end else begin
               rsp_status_in = selt_pkg::STATUS_NO_LOCK;
            end
         end
         default: begin
            state_in = selt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_shared_exclusive_lock_table_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for shared_exclusive_lock_table_core: directed and random
// lock, unlock and release requests, checked against a lock table model kept here.
// Depends on selt_pkg and the lock table RTL.

module tb_shared_exclusive_lock_table_core;

   localparam int TABLE_ENTRIES = 64;
   localparam int HANDLE_W      = 16;
   localparam int KEY_W         = 32;
   localparam int STALL_LIMIT   = 2000;
   localparam int SHOWN_LIMIT   = 10;

   localparam logic [3:0] OP_SH = 4'(1 << selt_pkg::OP_SHARED_BIT);
   localparam logic [3:0] OP_EX = 4'(1 << selt_pkg::OP_EXCLUSIVE_BIT);
   localparam logic [3:0] OP_NB = 4'(1 << selt_pkg::OP_NONBLOCK_BIT);
   localparam logic [3:0] OP_UN = 4'(1 << selt_pkg::OP_UNLOCK_BIT);

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_cmd;
   logic [HANDLE_W-1:0] req_holder_handle;
   logic [KEY_W-1:0]    req_object_key;
   logic [3:0]          req_op_bits;
   logic                rsp_valid;
   logic [2:0]          rsp_status;

   logic [HANDLE_W-1:0] tbl_holder    [TABLE_ENTRIES] = '{default: '0};
   logic [KEY_W-1:0]    tbl_object    [TABLE_ENTRIES] = '{default: '0};
   logic                tbl_exclusive [TABLE_ENTRIES] = '{default: 1'b0};

   logic [2:0] expected_status_q[$];
   int         error_count = 0;
   int         stall_cycles = 0;
   bit         idle_on = 1'b1;

   shared_exclusive_lock_table_core #(
      .ENTRIES    (TABLE_ENTRIES),
      .HANDLE_BITS(HANDLE_W),
      .KEY_BITS   (KEY_W)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_holder_handle(req_holder_handle),
      .req_object_key   (req_object_key),
      .req_op_bits      (req_op_bits),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int find_holder_slot(logic [HANDLE_W-1:0] handle);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_holder[i] == handle) return i;
      end
      return -1;
   endfunction

   function automatic void free_holder_entry(logic [HANDLE_W-1:0] handle);
      int slot;
      if (handle == '0) return;
      slot = find_holder_slot(handle);
      if (slot < 0) return;
      tbl_holder[slot]    = '0;
      tbl_object[slot]    = '0;
      tbl_exclusive[slot] = 1'b0;
   endfunction

   function automatic logic [2:0] predict_lock_status(logic cmd, logic [HANDLE_W-1:0] handle,
                                                      logic [KEY_W-1:0] key, logic [3:0] op);
      int   slot;
      logic want_ex;
      if (cmd == selt_pkg::CMD_RELEASE) begin
         free_holder_entry(handle);
         return selt_pkg::STATUS_OK;
      end
      if (handle == '0) return selt_pkg::STATUS_BAD_HANDLE;
      if (op[selt_pkg::OP_UNLOCK_BIT]) begin
         if (op[selt_pkg::OP_SHARED_BIT] || op[selt_pkg::OP_EXCLUSIVE_BIT])
            return selt_pkg::STATUS_INVALID;
         free_holder_entry(handle);
         return selt_pkg::STATUS_OK;
      end
      if (op[selt_pkg::OP_SHARED_BIT] == op[selt_pkg::OP_EXCLUSIVE_BIT])
         return selt_pkg::STATUS_INVALID;
      want_ex = op[selt_pkg::OP_EXCLUSIVE_BIT];
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_holder[i] != '0 && tbl_holder[i] != handle && tbl_object[i] == key &&
             (want_ex || tbl_exclusive[i]))
            return op[selt_pkg::OP_NONBLOCK_BIT] ? selt_pkg::STATUS_WOULDBLOCK :
                                                   selt_pkg::STATUS_NO_LOCK;
      end
      slot = find_holder_slot(handle);
      if (slot < 0) begin
         slot = find_holder_slot('0);
         if (slot < 0) return selt_pkg::STATUS_NO_LOCK;
         tbl_holder[slot] = handle;
         tbl_object[slot] = key;
      end
      tbl_exclusive[slot] = want_ex;
      return selt_pkg::STATUS_OK;
   endfunction

   task automatic send_beat(input logic cmd, input logic [HANDLE_W-1:0] handle,
                            input logic [KEY_W-1:0] key, input logic [3:0] op);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            @(posedge clock);
            while (busy !== 1'b0) @(posedge clock);
         end
         gap = $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_holder_handle <= handle;
      req_object_key    <= key;
      req_op_bits       <= op;
      do @(posedge clock); while (busy !== 1'b0);
      expected_status_q.push_back(predict_lock_status(cmd, handle, key, op));
   endtask

   task automatic run_contention(input int count);
      logic [HANDLE_W-1:0] handle_pool [6];
      logic [KEY_W-1:0]    key_pool [3];
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key;
      logic [3:0]          op;
      logic                cmd;
      int                  pick;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            foreach (handle_pool[i]) handle_pool[i] = HANDLE_W'($urandom_range(1, 65535));
            foreach (key_pool[i]) key_pool[i] = $urandom();
         end
         handle = handle_pool[$urandom_range(0, 5)];
         if ($urandom_range(0, 19) == 0) handle = '0;
         key = key_pool[$urandom_range(0, 2)];
         if ($urandom_range(0, 9) == 0) key = $urandom();
         pick = $urandom_range(0, 99);
         cmd  = selt_pkg::CMD_LOCK;
         if (pick < 10) begin
            cmd = selt_pkg::CMD_RELEASE;
            op  = 4'($urandom_range(0, 15));
         end else if (pick < 25) begin
            op = OP_UN | ($urandom_range(0, 1) ? OP_NB : 4'b0);
         end else if (pick < 35) begin
            op = 4'($urandom_range(0, 15));
         end else begin
            op = ($urandom_range(0, 1) ? OP_EX : OP_SH) | ($urandom_range(0, 1) ? OP_NB : 4'b0);
         end
         send_beat(cmd, handle, key, op);
      end
   endtask

   task automatic test_directed();
      logic [HANDLE_W-1:0] h1;
      logic [HANDLE_W-1:0] h2;
      logic [HANDLE_W-1:0] h3;
      logic [KEY_W-1:0]    k1;
      logic [KEY_W-1:0]    k2;
      h1 = '1;
      h2 = HANDLE_W'($urandom_range(2, 32767));
      h3 = HANDLE_W'(1);
      k1 = '1;
      k2 = '0;
      send_beat(selt_pkg::CMD_LOCK, '0, k1, OP_SH);
      send_beat(selt_pkg::CMD_LOCK, '0, k1, 4'b0);
      send_beat(selt_pkg::CMD_RELEASE, '0, $urandom(), 4'($urandom_range(0, 15)));
      send_beat(selt_pkg::CMD_LOCK, h1, k1, 4'b0);
      send_beat(selt_pkg::CMD_LOCK, h1, k1, OP_SH | OP_EX | OP_NB);
      send_beat(selt_pkg::CMD_LOCK, h1, k1, OP_UN | OP_SH);
      send_beat(selt_pkg::CMD_LOCK, h1, k1, OP_UN | OP_EX);
      send_beat(selt_pkg::CMD_LOCK, h1, k1, OP_UN);
      send_beat(selt_pkg::CMD_LOCK, h1, k1, OP_SH);
      send_beat(selt_pkg::CMD_LOCK, h2, k1, OP_SH | OP_NB);
      send_beat(selt_pkg::CMD_LOCK, h3, k1, OP_EX);
      send_beat(selt_pkg::CMD_LOCK, h3, k1, OP_EX | OP_NB);
      send_beat(selt_pkg::CMD_LOCK, h1, k1, OP_EX | OP_NB);
      send_beat(selt_pkg::CMD_LOCK, h2, k1, OP_UN | OP_NB);
      send_beat(selt_pkg::CMD_LOCK, h1, k2, OP_EX);
      send_beat(selt_pkg::CMD_LOCK, h3, k2, OP_EX);
      send_beat(selt_pkg::CMD_LOCK, h2, k1, OP_SH);
      send_beat(selt_pkg::CMD_RELEASE, h1, k2, 4'hF);
      send_beat(selt_pkg::CMD_LOCK, h2, k1, OP_SH);
      send_beat(selt_pkg::CMD_RELEASE, h1, k1, 4'b0);
      send_beat(selt_pkg::CMD_LOCK, h3, k1, OP_SH | OP_NB);
      send_beat(selt_pkg::CMD_RELEASE, h2, $urandom(), 4'($urandom_range(0, 15)));
      send_beat(selt_pkg::CMD_RELEASE, h3, $urandom(), 4'($urandom_range(0, 15)));
   endtask

   task automatic test_contention();
      run_contention(340);
   endtask

   task automatic test_table_full();
      logic [HANDLE_W-1:0] base;
      logic [KEY_W-1:0]    common_key;
      logic [KEY_W-1:0]    key;
      logic [3:0]          op;
      base       = HANDLE_W'($urandom_range(1, 65535 - TABLE_ENTRIES - 8));
      common_key = $urandom();
      for (int n = 0; n < TABLE_ENTRIES + 6; n++) begin
         if ($urandom_range(0, 1) == 1) begin
            op  = OP_SH;
            key = common_key;
         end else begin
            op  = OP_EX;
            key = $urandom();
         end
         op = op | ($urandom_range(0, 1) ? OP_NB : 4'b0);
         send_beat(selt_pkg::CMD_LOCK, base + HANDLE_W'(n), key, op);
      end
      for (int n = 0; n < TABLE_ENTRIES + 6; n++) begin
         if ($urandom_range(0, 1) == 1)
            send_beat(selt_pkg::CMD_RELEASE, base + HANDLE_W'(n), $urandom(),
                      4'($urandom_range(0, 15)));
         else
            send_beat(selt_pkg::CMD_LOCK, base + HANDLE_W'(n), $urandom(), OP_UN);
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      run_contention(150);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((start && busy === 1'b0) || rsp_valid === 1'b1) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_shared_exclusive_lock_table_core: done, errors");
            $finish;
         end
         if (rsp_valid === 1'b1) begin
            if (expected_status_q.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < SHOWN_LIMIT)
                  $display("%0t: unexpected result beat, status %0d", $realtime, rsp_status);
            end else begin
               if (rsp_status !== expected_status_q[0]) begin
                  error_count <= error_count + 1;
                  if (error_count < SHOWN_LIMIT)
                     $display("%0t: status mismatch, expected %0d, got %0d",
                              $realtime, expected_status_q[0], rsp_status);
               end
               void'(expected_status_q.pop_front());
            end
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      start             <= 1'b0;
      req_cmd           <= selt_pkg::CMD_LOCK;
      req_holder_handle <= '0;
      req_object_key    <= '0;
      req_op_bits       <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_contention();
      test_table_full();
      test_back_to_back();
      start <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 4) @(posedge clock);
      if (error_count == 0 && expected_status_q.size() == 0) begin
         $display("tb_shared_exclusive_lock_table_core: done, clean");
      end else begin
         $display("tb_shared_exclusive_lock_table_core: done, errors");
      end
      $finish;
   end

endmodule
